FILE: sv/gwm_pkg.sv
// Shared types, constants and helpers for the glob wildcard matcher.
// No dependencies; every other file of the block but gwm_checker imports this package.
`timescale 1ns / 1ps

package gwm_pkg;

  localparam int MAX_TOKENS  = 64;
  localparam int CNT_W       = $clog2(MAX_TOKENS + 1);
  localparam int POS_W       = $clog2(MAX_TOKENS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_QUES = 8'h3F;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    OP_NEW  = 2'd0,
    OP_PAT  = 2'd1,
    OP_DATA = 2'd2,
    OP_END  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_ANY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_NEW  = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DATA = 2'd2,
    CMD_END  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       wr_tok;
    logic       set_ovf;
    kind_e      kind;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic matched;
    logic status;
  } res_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c, input logic cs);
    logic [7:0] r;
    r = c;
    if (!cs && (c inside {[CH_UP_A:CH_UP_Z]})) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

FILE: sv/glob_wildcard_matcher_top.sv
// Top level of the glob wildcard matcher: front end, command queue, back end.
// Throughput is one beat per cycle while the command queue is not full; the back end settles one command per cycle
// unless an end-of-data command waits on a full result queue. An end-of-data beat is written to the command queue,
// then its result to the two-entry result queue, and it waits while that result queue is full.
// Reset is asynchronous and active low; it clears the pattern, the case-sensitive
// register and both queues, and the block accepts beats on the first cycle after.
`timescale 1ns / 1ps

module glob_wildcard_matcher_top import gwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op_i,
  input  logic [7:0] char_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       matched_o,
  output logic       status_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic q_wr;
  cmd_t q_wdata;
  logic q_valid;
  logic q_rd;
  cmd_t q_rdata;

  gwm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .op_i        (op_i),
    .char_byte_i (char_byte_i),
    .q_full_i    (full),
    .q_wr_o      (q_wr),
    .q_data_o    (q_wdata)
  );

  gwm_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (full),
    .valid_o (q_valid),
    .rd_i    (q_rd),
    .rdata_o (q_rdata)
  );

  gwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_rdata),
    .cmd_rd_o    (q_rd),
    .empty       (empty),
    .pop         (pop),
    .matched_o   (matched_o),
    .status_o    (status_o)
  );

endmodule

FILE: sv/gwm_front.sv
// Front end: accepts input beats and turns them into back-end commands.
// Tracks escapes, star collapsing and the token count. Depends on gwm_pkg.
`timescale 1ns / 1ps

module gwm_front import gwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic [1:0] op_i,
  input  logic [7:0] char_byte_i,
  input  logic       q_full_i,
  output logic       q_wr_o,
  output cmd_t       q_data_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             esc_q, esc_d;
  logic             last_star_q, last_star_d;
  logic             accept;
  logic             add_tok;
  kind_e            add_kind;
  logic [7:0]       add_ch;

  assign accept = push && !q_full_i;
  assign q_wr_o = accept;

  always_comb begin
    cnt_d       = cnt_q;
    esc_d       = esc_q;
    last_star_d = last_star_q;
    add_tok     = 1'b0;
    add_kind    = KIND_LIT;
    add_ch      = char_byte_i;
    q_data_o    = '{cmd: CMD_DATA, wr_tok: 1'b0, set_ovf: 1'b0, kind: KIND_LIT,
                    ch: char_byte_i};
    case (op_e'(op_i))
      OP_NEW: begin
        q_data_o.cmd = CMD_NEW;
        cnt_d        = '0;
        esc_d        = 1'b0;
        last_star_d  = 1'b0;
      end
      OP_PAT: begin
        q_data_o.cmd = CMD_ADD;
        if (esc_q) begin
          esc_d   = 1'b0;
          add_tok = 1'b1;
        end else if (char_byte_i == CH_BSL) begin
          esc_d = 1'b1;
        end else if (char_byte_i == CH_STAR) begin
          add_tok  = !last_star_q;
          add_kind = KIND_ANY;
          add_ch   = '0;
        end else if (char_byte_i == CH_QUES) begin
          add_tok  = 1'b1;
          add_kind = KIND_ONE;
          add_ch   = '0;
        end else begin
          add_tok = 1'b1;
        end
        if (add_tok) begin
          if (cnt_q >= CNT_W'(MAX_TOKENS)) begin
            q_data_o.set_ovf = 1'b1;
          end else begin
            q_data_o.wr_tok = 1'b1;
            cnt_d           = cnt_q + CNT_W'(1);
            last_star_d     = (add_kind == KIND_ANY);
          end
        end
        q_data_o.kind = add_kind;
        q_data_o.ch   = add_ch;
      end
      OP_DATA: begin
        q_data_o.cmd = CMD_DATA;
      end
      OP_END: begin
        q_data_o.cmd = CMD_END;
      end
      default: begin
        q_data_o.cmd = CMD_END;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      esc_q       <= 1'b0;
      last_star_q <= 1'b0;
    end else if (accept) begin
      cnt_q       <= cnt_d;
      esc_q       <= esc_d;
      last_star_q <= last_star_d;
    end
  end

endmodule

FILE: sv/gwm_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on gwm_pkg for the command type and queue sizing.
`timescale 1ns / 1ps

module gwm_cmd_queue import gwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  output logic full_o,
  output logic valid_o,
  input  logic rd_i,
  output cmd_t rdata_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_wr, do_rd;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/gwm_back.sv
// Back end: token store, active-position vector and the result queue.
// Advances all positions in one step per data byte. Depends on gwm_pkg.
`timescale 1ns / 1ps

module gwm_back import gwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_rd_o,
  output logic empty,
  input  logic pop,
  output logic matched_o,
  output logic status_o
);

  kind_e             kind_q [MAX_TOKENS];
  logic [7:0]        lit_q  [MAX_TOKENS];
  logic [CNT_W-1:0]  cnt_q;
  logic              ovf_q;
  logic              cs_q;
  logic [MAX_TOKENS:0] act_q, act_d, cur, nxt;
  logic [MAX_TOKENS-1:0] lane_v, star, adv;
  logic [7:0]        data_f;
  logic              fire;
  logic              hit;

  res_t              res_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] res_wptr_q, res_rptr_q;
  logic [QCNT_W-1:0] res_cnt_q;
  logic              res_full, res_wr, res_rd;

  assign res_full = (res_cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (res_cnt_q == '0);
  assign res_rd   = pop && !empty;
  assign matched_o = res_q[res_rptr_q].matched;
  assign status_o  = res_q[res_rptr_q].status;

  assign fire     = cmd_valid_i && !((cmd_i.cmd == CMD_END) && res_full);
  assign cmd_rd_o = fire;
  assign res_wr   = fire && (cmd_i.cmd == CMD_END);
  assign data_f   = fold_case(cmd_i.ch, cs_q);

  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      lane_v[i] = (CNT_W'(i) < cnt_q);
      star[i]   = lane_v[i] && (kind_q[i] == KIND_ANY);
      adv[i]    = lane_v[i] && ((kind_q[i] == KIND_ONE) ||
                  ((kind_q[i] == KIND_LIT) && (fold_case(lit_q[i], cs_q) == data_f)));
    end
  end

  // Stars never sit next to each other in the store, so one level of
  // closure is enough.
  always_comb begin
    cur = act_q;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      cur[i+1] = act_q[i+1] | (act_q[i] & star[i]);
    end
    nxt = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      nxt[i]   = nxt[i] | (cur[i] & star[i]);
      nxt[i+1] = nxt[i+1] | (cur[i] & adv[i]);
    end
  end

  assign hit = !ovf_q && cur[cnt_q];

  always_comb begin
    act_d = act_q;
    if (fire) begin
      if (cmd_i.cmd == CMD_DATA) begin
        act_d = nxt;
      end else begin
        act_d = (MAX_TOKENS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && (cmd_i.cmd == CMD_ADD) && cmd_i.wr_tok) begin
      kind_q[cnt_q[POS_W-1:0]] <= cmd_i.kind;
      lit_q[cnt_q[POS_W-1:0]]  <= cmd_i.ch;
    end
    if (res_wr) begin
      res_q[res_wptr_q] <= '{matched: hit, status: ovf_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      cs_q       <= 1'b0;
      act_q      <= (MAX_TOKENS+1)'(1);
      res_wptr_q <= '0;
      res_rptr_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      act_q <= act_d;
      if (cfg_we_i) begin
        cs_q <= cfg_wdata_i;
      end
      if (fire) begin
        case (cmd_i.cmd)
          CMD_NEW: begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
          CMD_ADD: begin
            if (cmd_i.wr_tok) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            if (cmd_i.set_ovf) begin
              ovf_q <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (res_wr) begin
        res_wptr_q <= res_wptr_q + QPTR_W'(1);
      end
      if (res_rd) begin
        res_rptr_q <= res_rptr_q + QPTR_W'(1);
      end
      if (res_wr && !res_rd) begin
        res_cnt_q <= res_cnt_q + QCNT_W'(1);
      end else if (res_rd && !res_wr) begin
        res_cnt_q <= res_cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/gwm_checker.sv
// Port-level checks for the glob wildcard matcher, bound to the top level.
// Depends only on the ports of glob_wildcard_matcher_top.
`timescale 1ns / 1ps

module gwm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic matched_o,
  input logic status_o
);

  // An overflowed pattern never reports a match.
  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> !matched_o)
    else $error("overflow status with a match");

  // The command queue only fills after a beat was offered the cycle before.
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("queue filled without an input beat");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result beat vanished");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(matched_o) && $stable(status_o)))
    else $error("waiting result beat changed");

endmodule

bind glob_wildcard_matcher_top gwm_checker u_gwm_checker (.*);

FILE: tb/glob_wildcard_matcher_top_tb.sv
// Self-checking testbench for glob_wildcard_matcher_top: directed and random patterns and strings.
// Depends on gwm_pkg and the block's RTL; a built-in predictor checks every result beat.
`timescale 1ns / 1ps

module glob_wildcard_matcher_top_tb import gwm_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BEATS    = 320;

  typedef struct {
    op_e        op;
    logic [7:0] ch;
  } beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [1:0] op_i        = OP_NEW;
  logic [7:0] char_byte_i = 8'h00;
  logic       empty;
  logic       pop         = 1'b0;
  logic       matched_o;
  logic       status_o;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;

  beat_t      to_send[$];
  res_t       verdicts[$];
  int         queued     = 0;
  int         errors     = 0;
  int         send_gap   = 0;
  int         pop_gap    = 0;
  int         idle_count = 0;
  bit         idle_on    = 1'b1;

  kind_e            pat_kind[MAX_TOKENS];
  logic [7:0]       pat_ch[MAX_TOKENS];
  int               tok_len    = 0;
  bit               esc_open   = 1'b0;
  bit               pat_ovf    = 1'b0;
  bit               case_exact = 1'b0;
  logic [MAX_TOKENS:0] live    = (MAX_TOKENS+1)'(1);

  kind_e      gen_kind[$];
  logic [7:0] gen_ch[$];
  logic [7:0] str_q[$];

  glob_wildcard_matcher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .char_byte_i (char_byte_i),
    .empty       (empty),
    .pop         (pop),
    .matched_o   (matched_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    if (!case_exact && c >= "A" && c <= "Z") begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic [MAX_TOKENS:0] star_pass(logic [MAX_TOKENS:0] v);
    for (int i = 0; i < tok_len; i++) begin
      if (v[i] && pat_kind[i] == KIND_ANY) begin
        v[i + 1] = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic void store_token(kind_e k, logic [7:0] c);
    if (tok_len >= MAX_TOKENS) begin
      pat_ovf = 1'b1;
    end else begin
      pat_kind[tok_len] = k;
      pat_ch[tok_len]   = c;
      tok_len++;
    end
  endfunction

  function automatic void add_pattern_byte(logic [7:0] c);
    if (esc_open) begin
      esc_open = 1'b0;
      store_token(KIND_LIT, c);
    end else if (c == CH_BSL) begin
      esc_open = 1'b1;
    end else if (c == CH_STAR) begin
      if (!(tok_len > 0 && pat_kind[tok_len - 1] == KIND_ANY)) begin
        store_token(KIND_ANY, 8'h00);
      end
    end else if (c == CH_QUES) begin
      store_token(KIND_ONE, 8'h00);
    end else begin
      store_token(KIND_LIT, c);
    end
  endfunction

  function automatic void apply_beat(op_e op, logic [7:0] c);
    logic [MAX_TOKENS:0] cur;
    logic [MAX_TOKENS:0] nxt;
    res_t r;
    case (op)
      OP_NEW: begin
        tok_len  = 0;
        esc_open = 1'b0;
        pat_ovf  = 1'b0;
        live     = (MAX_TOKENS+1)'(1);
      end
      OP_PAT: begin
        add_pattern_byte(c);
        live = (MAX_TOKENS+1)'(1);
      end
      OP_DATA: begin
        cur = star_pass(live);
        nxt = '0;
        for (int i = 0; i < tok_len; i++) begin
          if (cur[i]) begin
            case (pat_kind[i])
              KIND_ANY: nxt[i] = 1'b1;
              KIND_ONE: nxt[i + 1] = 1'b1;
              default: begin
                if (lower_ascii(pat_ch[i]) == lower_ascii(c)) begin
                  nxt[i + 1] = 1'b1;
                end
              end
            endcase
          end
        end
        live = nxt;
      end
      default: begin
        cur       = star_pass(live);
        r.matched = !pat_ovf && cur[tok_len];
        r.status  = pat_ovf;
        verdicts.push_back(r);
        live = (MAX_TOKENS+1)'(1);
      end
    endcase
  endfunction

  task automatic add(op_e op, logic [7:0] c);
    beat_t b;
    b.op = op;
    b.ch = c;
    to_send.push_back(b);
    queued++;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0: return "a";
      1: return "b";
      2: return "A";
      3: return "B";
      4: return "z";
      5: return "Z";
      6: return CH_STAR;
      7: return CH_QUES;
      8: return CH_BSL;
      9: return 8'h00;
      10: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] b);
    if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) && $urandom_range(0, 2) == 0) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  // One pattern followed by a few strings derived from it, some of them corrupted.
  task automatic build_sequence();
    int n;
    int r;
    int reps;
    int pos;
    gen_kind.delete();
    gen_ch.delete();
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 5);
      if (r == 0) begin
        gen_kind.push_back(KIND_ANY);
        gen_ch.push_back(8'h00);
      end else if (r == 1) begin
        gen_kind.push_back(KIND_ONE);
        gen_ch.push_back(8'h00);
      end else begin
        gen_kind.push_back(KIND_LIT);
        gen_ch.push_back(pick_byte());
      end
    end
    add(OP_NEW, 8'($urandom_range(0, 255)));
    for (int i = 0; i < gen_kind.size(); i++) begin
      if (gen_kind[i] == KIND_ANY) begin
        add(OP_PAT, CH_STAR);
        if ($urandom_range(0, 3) == 0) begin
          add(OP_PAT, CH_STAR);
        end
      end else if (gen_kind[i] == KIND_ONE) begin
        add(OP_PAT, CH_QUES);
      end else begin
        if (gen_ch[i] == CH_STAR || gen_ch[i] == CH_QUES || gen_ch[i] == CH_BSL ||
            $urandom_range(0, 7) == 0) begin
          add(OP_PAT, CH_BSL);
        end
        add(OP_PAT, gen_ch[i]);
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      add(OP_PAT, CH_BSL);
    end
    reps = $urandom_range(1, 4);
    for (int k = 0; k < reps; k++) begin
      str_q.delete();
      for (int i = 0; i < gen_kind.size(); i++) begin
        if (gen_kind[i] == KIND_ANY) begin
          repeat ($urandom_range(0, 3)) str_q.push_back(pick_byte());
        end else if (gen_kind[i] == KIND_ONE) begin
          str_q.push_back(pick_byte());
        end else begin
          str_q.push_back(flip_case(gen_ch[i]));
        end
      end
      if (str_q.size() != 0 && $urandom_range(0, 4) == 0) begin
        pos = $urandom_range(0, str_q.size() - 1);
        str_q[pos] = pick_byte();
      end
      if ($urandom_range(0, 9) == 0) begin
        str_q.push_back(pick_byte());
      end
      if (str_q.size() != 0 && $urandom_range(0, 9) == 0) begin
        void'(str_q.pop_back());
      end
      foreach (str_q[i]) begin
        add(OP_DATA, str_q[i]);
      end
      add(OP_END, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) add(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    while (to_send.size() != 0 || push || verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_case(bit v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i) begin : drive
    beat_t nxt_beat;
    if (cfg_we_i) begin
      case_exact = cfg_wdata_i;
    end
    if (rst_ni) begin
      if (push && !full) begin
        apply_beat(op_e'(op_i), char_byte_i);
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (to_send.size() != 0) begin
        nxt_beat    = to_send.pop_front();
        push        <= 1'b1;
        op_i        <= nxt_beat.op;
        char_byte_i <= nxt_beat.ch;
        if (idle_on && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 16);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : take
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (verdicts.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual matched %0b status %0b",
                   $time, matched_o, status_o);
          errors++;
        end else begin
          want = verdicts.pop_front();
          if (matched_o !== want.matched) begin
            $display("%0t: matched mismatch, expected %0b actual %0b",
                     $time, want.matched, matched_o);
            errors++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status mismatch, expected %0b actual %0b",
                     $time, want.status, status_o);
            errors++;
          end
        end
      end
      if (!idle_on) begin
        pop_gap = 0;
        pop <= 1'b1;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 7) == 0) begin
          pop_gap = $urandom_range(1, 16);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count == WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_case(1'b0);
    add(OP_END, 8'hFF);
    add(OP_NEW, 8'h00);
    add(OP_PAT, "A");
    add(OP_PAT, CH_BSL);
    add(OP_PAT, CH_STAR);
    add(OP_PAT, CH_QUES);
    add(OP_PAT, CH_BSL);
    add(OP_DATA, "a");
    add(OP_DATA, CH_STAR);
    add(OP_DATA, 8'h00);
    add(OP_END, 8'h00);
    add(OP_NEW, 8'hFF);
    add(OP_PAT, CH_STAR);
    add(OP_PAT, CH_STAR);
    add(OP_END, 8'h00);
    add(OP_DATA, 8'hFF);
    add(OP_END, 8'h00);
    add(OP_NEW, 8'h00);
    add(OP_PAT, CH_QUES);
    add(OP_DATA, "q");
    add(OP_PAT, "z");
    add(OP_DATA, "k");
    add(OP_DATA, "Z");
    add(OP_END, 8'h00);
    for (int p = 0; p < 5; p++) begin
      drain();
      set_case(p % 2 == 0);
      idle_on = (p != 4);
      start = queued;
      while (queued - start < PHASE_BEATS) begin
        build_sequence();
      end
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
